>>> rtl/fuzzy_steering_inference_top_defines.svh
// ----------------------------------------------------------------------------
// Fuzzy steering inference: assertion macros
// Immediate-step and next-cycle implication checks used by the top level.
// ----------------------------------------------------------------------------
`ifndef FUZZY_STEERING_INFERENCE_TOP_DEFINES_SVH
`define FUZZY_STEERING_INFERENCE_TOP_DEFINES_SVH

// same-cycle implication
`define FSI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/fsi_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy steering inference package
// Types, codes, widths and the exponential tables shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package fsi_pkg;

	localparam int DEF_NUM_RULES  = 10;
	localparam int DEF_NUM_INPUTS = 4;

	localparam int DIST_W   = 16;
	localparam int CENTRE_W = 15;
	localparam int SPREAD_W = 13;
	localparam int CONS_W   = 15;
	localparam int MU_W     = 17;
	localparam int STEER_QW = 16;

	localparam logic [1:0] FUNC_SET  = 2'd0;
	localparam logic [1:0] FUNC_EVAL = 2'd1;
	localparam logic [1:0] FUNC_CONS = 2'd2;

	localparam logic [1:0] MARK_ABOVE = 2'b01;
	localparam logic [1:0] MARK_BELOW = 2'b11;

	localparam logic [MU_W-1:0] MU_ONE  = 17'd65536;
	localparam logic [7:0]      Q_LIMIT = 8'd192;
	localparam logic [3:0]      LANE_DIV_LAST = 4'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_SQ,
		S_LD,
		S_DIV,
		S_EXP,
		S_PHI,
		S_ACC,
		S_FIN,
		S_FDIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic div_load;
		logic div_step;
	} lane_ctrl_t;

	function automatic logic [16:0] exp_int(input logic [3:0] k);
		logic [16:0] v;
		case (k)
			4'd0:  v = 17'd65536;
			4'd1:  v = 17'd24109;
			4'd2:  v = 17'd8869;
			4'd3:  v = 17'd3263;
			4'd4:  v = 17'd1200;
			4'd5:  v = 17'd442;
			4'd6:  v = 17'd162;
			4'd7:  v = 17'd60;
			4'd8:  v = 17'd22;
			4'd9:  v = 17'd8;
			4'd10: v = 17'd3;
			4'd11: v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	function automatic logic [16:0] exp_frac(input logic [3:0] i);
		logic [16:0] v;
		case (i)
			4'd0:  v = 17'd65536;
			4'd1:  v = 17'd61565;
			4'd2:  v = 17'd57835;
			4'd3:  v = 17'd54331;
			4'd4:  v = 17'd51039;
			4'd5:  v = 17'd47947;
			4'd6:  v = 17'd45042;
			4'd7:  v = 17'd42313;
			4'd8:  v = 17'd39750;
			4'd9:  v = 17'd37341;
			4'd10: v = 17'd35079;
			4'd11: v = 17'd32954;
			4'd12: v = 17'd30957;
			4'd13: v = 17'd29081;
			4'd14: v = 17'd27319;
			4'd15: v = 17'd25664;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/fsi_lane.sv
// ----------------------------------------------------------------------------
// Fuzzy steering inference: membership lane
// Holds one input's Gaussian sets for every rule and evaluates the
// membership of the held distance against the addressed rule.
// ----------------------------------------------------------------------------
`default_nettype none

module fsi_lane #(
	parameter  int NUM_RULES = fsi_pkg::DEF_NUM_RULES,
	localparam int RA_W      = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [RA_W-1:0]                 wr_addr,
	input  wire logic [fsi_pkg::CENTRE_W-1:0]    wr_centre,
	input  wire logic [fsi_pkg::SPREAD_W-1:0]    wr_spread,
	input  wire logic [1:0]                      wr_mark,
	input  wire logic [RA_W-1:0]                 rd_addr,
	input  wire logic [fsi_pkg::DIST_W-1:0]      x,
	input  wire fsi_pkg::lane_ctrl_t             ctrl,
	output logic      [fsi_pkg::MU_W-1:0]        mu
);

	logic [fsi_pkg::CENTRE_W-1:0] centre_mem [NUM_RULES];
	logic [fsi_pkg::SPREAD_W-1:0] spread_mem [NUM_RULES];
	logic [1:0]                   mark_q     [NUM_RULES];

	logic [fsi_pkg::CENTRE_W-1:0] centre_s1;
	logic [fsi_pkg::SPREAD_W-1:0] spread_s1;
	logic [1:0]                   mark_s1;

	logic [fsi_pkg::DIST_W-1:0]   c_ext;
	logic [fsi_pkg::DIST_W-1:0]   d;
	logic [fsi_pkg::SPREAD_W-1:0] w_eff;
	logic                         sat;

	logic        sat_s2;
	logic [31:0] d2_s2;
	logic [25:0] w2_s2;

	logic [36:0] num_c;
	logic [26:0] den2_c;
	logic [36:0] rem_q;
	logic [33:0] dsh_q;
	logic [7:0]  q_q;
	logic        ovf_q;

	logic        zero;
	logic [32:0] prod;
	logic [fsi_pkg::MU_W-1:0] mu_s4;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			centre_mem[wr_addr] <= wr_centre;
			spread_mem[wr_addr] <= wr_spread;
		end
		centre_s1 <= centre_mem[rd_addr];
		spread_s1 <= spread_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RULES; i++) begin
				mark_q[i] <= 2'b00;
			end
		end else if (wr_en) begin
			mark_q[wr_addr] <= wr_mark;
		end
	end

	always_ff @(posedge clk) begin
		mark_s1 <= mark_q[rd_addr];
	end

	always_comb begin
		c_ext = {1'b0, centre_s1};
		sat   = ((mark_s1 == fsi_pkg::MARK_ABOVE) && (x > c_ext)) ||
		        ((mark_s1 == fsi_pkg::MARK_BELOW) && (x < c_ext));
		w_eff = (spread_s1 == '0) ? 13'd1 : spread_s1;
		d     = (x >= c_ext) ? (x - c_ext) : (c_ext - x);
	end

	always_ff @(posedge clk) begin
		sat_s2 <= sat;
		d2_s2  <= 32'(d) * 32'(d);
		w2_s2  <= 26'(w_eff) * 26'(w_eff);
	end

	assign num_c  = {1'b0, d2_s2, 4'b0000} + 37'(w2_s2);
	assign den2_c = {w2_s2, 1'b0};

	always_ff @(posedge clk) begin
		if (ctrl.div_load) begin
			rem_q <= num_c;
			dsh_q <= {den2_c, 7'b0};
			q_q   <= '0;
			ovf_q <= num_c >= {2'b00, den2_c, 8'b0};
		end else if (ctrl.div_step) begin
			if (rem_q >= 37'(dsh_q)) begin
				rem_q <= rem_q - 37'(dsh_q);
				q_q   <= {q_q[6:0], 1'b1};
			end else begin
				q_q   <= {q_q[6:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign zero = ovf_q || (q_q >= fsi_pkg::Q_LIMIT);
	assign prod = 33'(fsi_pkg::exp_int(q_q[7:4])) * 33'(fsi_pkg::exp_frac(q_q[3:0]));

	always_ff @(posedge clk) begin
		if (sat_s2) begin
			mu_s4 <= fsi_pkg::MU_ONE;
		end else if (zero) begin
			mu_s4 <= '0;
		end else begin
			mu_s4 <= 17'((prod + 33'd32768) >> 16);
		end
	end

	assign mu = mu_s4;

endmodule

`default_nettype wire

>>> rtl/fsi_divider.sv
// ----------------------------------------------------------------------------
// Fuzzy steering inference: output divider
// Restoring divider, one quotient bit a cycle, for the weighted average.
// ----------------------------------------------------------------------------
`default_nettype none

module fsi_divider #(
	parameter int NW = 37,
	parameter int DW = 21,
	parameter int QW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic      [QW-1:0] quotient,
	output logic               done
);

	localparam int CW = $clog2(QW + 1);
	localparam int SW = DW + QW - 1;

	logic [NW-1:0] rem_q;
	logic [SW-1:0] dsh_q;
	logic [QW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(QW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsh_q  <= {divisor, {(QW-1){1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (rem_q >= NW'(dsh_q)) begin
				rem_q  <= rem_q - NW'(dsh_q);
				quot_q <= {quot_q[QW-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[QW-2:0], 1'b0};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign quotient = quot_q;
	assign done     = done_q;

endmodule

`default_nettype wire

>>> rtl/fuzzy_steering_inference_top.sv
// ----------------------------------------------------------------------------
// Fuzzy steering inference top level
// Zero-order Takagi-Sugeno inference over a loaded rule table.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries write and evaluate items.
// A set write or consequent write gives no result.
// An evaluate item walks the rules one at a time; the membership lanes
// (one per distance) each run an eight-bit quotient search, then the
// memberships are multiplied into the firing strength one lane a cycle.
// After the last rule a divider forms the weighted average, and one
// evaluate is in flight at a time.
// The result sits in an output register (out_valid / out_stall); a new item
// is taken while it waits, and an evaluate that finishes before the old
// result is taken holds until it is.
// Reset clears the boundary marks and the control state; centres, widths
// and consequents stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fuzzy_steering_inference_top_defines.svh"

module fuzzy_steering_inference_top #(
	parameter int NUM_RULES  = fsi_pkg::DEF_NUM_RULES,
	parameter int NUM_INPUTS = fsi_pkg::DEF_NUM_INPUTS
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic        [1:0]                    func,
	input  wire logic        [3:0]                    rule_index,
	input  wire logic        [1:0]                    input_index,
	input  wire logic        [fsi_pkg::CENTRE_W-1:0]  centre,
	input  wire logic        [fsi_pkg::SPREAD_W-1:0]  spread,
	input  wire logic signed [1:0]                    edge_mark,
	input  wire logic signed [fsi_pkg::CONS_W-1:0]    consequent,
	input  wire logic        [fsi_pkg::DIST_W-1:0]    dist0,
	input  wire logic        [fsi_pkg::DIST_W-1:0]    dist1,
	input  wire logic        [fsi_pkg::DIST_W-1:0]    dist2,
	input  wire logic        [fsi_pkg::DIST_W-1:0]    dist3,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed      [fsi_pkg::CONS_W-1:0]    steer,
	output logic                                      den_floored
);

	localparam int RA_W  = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
	localparam int KW    = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
	localparam int DEN_W = fsi_pkg::MU_W + $clog2(NUM_RULES);
	localparam int NUM_W = 33 + $clog2(NUM_RULES);

	fsi_pkg::state_t     state_q, state_d;
	fsi_pkg::lane_ctrl_t lane_ctrl;

	logic acc, eval_acc, set_we, cons_we;
	logic fdiv_start, out_load;

	logic [RA_W-1:0] rule_q;
	logic [3:0]      cnt_q;
	logic [KW-1:0]   k_q;

	logic [fsi_pkg::DIST_W-1:0] dist_in [4];
	logic [fsi_pkg::DIST_W-1:0] x_q     [NUM_INPUTS];
	logic [fsi_pkg::MU_W-1:0]   mu      [NUM_INPUTS];

	logic signed [fsi_pkg::CONS_W-1:0] cons_mem [NUM_RULES];
	logic signed [fsi_pkg::CONS_W-1:0] cons_s1;

	logic        [fsi_pkg::MU_W-1:0] phi_q;
	logic        [DEN_W-1:0]         den_q;
	logic signed [NUM_W-1:0]         num_q;
	logic signed [32:0]              term;

	logic                    floored_c, floored_q, neg_q;
	logic [DEN_W-1:0]        den_eff;
	logic [NUM_W-1:0]        mag, dividend;
	logic [fsi_pkg::STEER_QW-1:0] quot;
	logic                    fdiv_done;

	logic signed [fsi_pkg::CONS_W-1:0] steer_q;
	logic                              den_floored_q;
	logic                              out_valid_q;

	assign in_stall = (state_q != fsi_pkg::S_IDLE);
	assign acc      = in_valid && !in_stall;
	assign eval_acc = acc && (func == fsi_pkg::FUNC_EVAL);
	assign set_we   = acc && (func == fsi_pkg::FUNC_SET) &&
	                  ({1'b0, rule_index} < 5'(NUM_RULES)) &&
	                  ({1'b0, input_index} < 3'(NUM_INPUTS));
	assign cons_we  = acc && (func == fsi_pkg::FUNC_CONS) &&
	                  ({1'b0, rule_index} < 5'(NUM_RULES));

	assign dist_in[0] = dist0;
	assign dist_in[1] = dist1;
	assign dist_in[2] = dist2;
	assign dist_in[3] = dist3;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fsi_pkg::S_IDLE: if (eval_acc) state_d = fsi_pkg::S_RD;
			fsi_pkg::S_RD:   state_d = fsi_pkg::S_SQ;
			fsi_pkg::S_SQ:   state_d = fsi_pkg::S_LD;
			fsi_pkg::S_LD:   state_d = fsi_pkg::S_DIV;
			fsi_pkg::S_DIV:  if (cnt_q == fsi_pkg::LANE_DIV_LAST) state_d = fsi_pkg::S_EXP;
			fsi_pkg::S_EXP:  state_d = fsi_pkg::S_PHI;
			fsi_pkg::S_PHI:  if (k_q == KW'(NUM_INPUTS - 1)) state_d = fsi_pkg::S_ACC;
			fsi_pkg::S_ACC: begin
				if (rule_q == RA_W'(NUM_RULES - 1)) state_d = fsi_pkg::S_FIN;
				else state_d = fsi_pkg::S_RD;
			end
			fsi_pkg::S_FIN:  state_d = fsi_pkg::S_FDIV;
			fsi_pkg::S_FDIV: if (fdiv_done) state_d = fsi_pkg::S_OUT;
			fsi_pkg::S_OUT:  if (!out_valid_q || !out_stall) state_d = fsi_pkg::S_IDLE;
			default:         state_d = fsi_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		lane_ctrl.div_load = (state_q == fsi_pkg::S_LD);
		lane_ctrl.div_step = (state_q == fsi_pkg::S_DIV);
		fdiv_start         = (state_q == fsi_pkg::S_FIN);
		out_load           = (state_q == fsi_pkg::S_OUT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsi_pkg::S_IDLE;
			rule_q      <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				fsi_pkg::S_IDLE: rule_q <= '0;
				fsi_pkg::S_LD:   cnt_q  <= '0;
				fsi_pkg::S_DIV:  cnt_q  <= cnt_q + 1'b1;
				fsi_pkg::S_EXP:  k_q    <= '0;
				fsi_pkg::S_PHI:  k_q    <= k_q + 1'b1;
				fsi_pkg::S_ACC:  rule_q <= rule_q + 1'b1;
				default: ;
			endcase
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cons_we) cons_mem[rule_index[RA_W-1:0]] <= consequent;
		cons_s1 <= cons_mem[rule_q];
	end

	assign term = $signed({1'b0, phi_q}) * cons_s1;

	always_ff @(posedge clk) begin
		if (eval_acc) begin
			for (int j = 0; j < NUM_INPUTS; j++) begin
				x_q[j] <= dist_in[j];
			end
			num_q <= '0;
			den_q <= '0;
		end
		case (state_q)
			fsi_pkg::S_EXP: phi_q <= fsi_pkg::MU_ONE;
			fsi_pkg::S_PHI: phi_q <= 17'((34'(phi_q) * 34'(mu[k_q]) + 34'd32768) >> 16);
			fsi_pkg::S_ACC: begin
				den_q <= den_q + DEN_W'(phi_q);
				num_q <= num_q + NUM_W'(term);
			end
			fsi_pkg::S_FIN: begin
				floored_q <= floored_c;
				neg_q     <= num_q[NUM_W-1];
			end
			default: ;
		endcase
		if (out_load) begin
			steer_q       <= 15'(neg_q ? (~quot + 1'b1) : quot);
			den_floored_q <= floored_q;
		end
	end

	assign floored_c = (den_q == '0);
	assign den_eff   = floored_c ? DEN_W'(1) : den_q;
	assign mag       = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign dividend  = mag + NUM_W'(den_eff >> 1);

	for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_lane
		fsi_lane #(
			.NUM_RULES (NUM_RULES)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (set_we && (input_index == 2'(g))),
			.wr_addr   (rule_index[RA_W-1:0]),
			.wr_centre (centre),
			.wr_spread (spread),
			.wr_mark   (edge_mark),
			.rd_addr   (rule_q),
			.x         (x_q[g]),
			.ctrl      (lane_ctrl),
			.mu        (mu[g])
		);
	end

	fsi_divider #(
		.NW (NUM_W),
		.DW (DEN_W),
		.QW (fsi_pkg::STEER_QW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (fdiv_start),
		.dividend (dividend),
		.divisor  (den_eff),
		.quotient (quot),
		.done     (fdiv_done)
	);

	assign out_valid   = out_valid_q;
	assign steer       = steer_q;
	assign den_floored = den_floored_q;

	`FSI_ASSERT_IMP(a_floored_zero, clk, arst_n, out_valid && den_floored, steer == '0, "floored result not zero")
	`FSI_ASSERT_NEXT(a_eval_busy, clk, arst_n, eval_acc, in_stall, "evaluate transfer did not start a walk")
	`FSI_ASSERT_IMP(a_out_source, clk, arst_n, $rose(out_valid), $past(state_q == fsi_pkg::S_OUT), "result raised outside output step")

endmodule

`default_nettype wire

>>> sim/fuzzy_steering_inference_checker.sv
// ----------------------------------------------------------------------------
// Fuzzy steering inference checker
// Watches both channels, keeps its own copy of the rule table, predicts
// the steering value of every evaluate transfer and compares each output
// transfer, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module fuzzy_steering_inference_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic [1:0]         func,
	input  wire logic [3:0]         rule_index,
	input  wire logic [1:0]         input_index,
	input  wire logic [14:0]        centre,
	input  wire logic [12:0]        spread,
	input  wire logic signed [1:0]  edge_mark,
	input  wire logic signed [14:0] consequent,
	input  wire logic [15:0]        dist0,
	input  wire logic [15:0]        dist1,
	input  wire logic [15:0]        dist2,
	input  wire logic [15:0]        dist3,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [14:0] steer,
	input  wire logic               den_floored,
	output int                      errors,
	output int                      pending
);

	localparam int RULES  = fsi_pkg::DEF_NUM_RULES;
	localparam int INPUTS = fsi_pkg::DEF_NUM_INPUTS;

	typedef struct {
		logic signed [14:0] steer;
		logic               floored;
	} steer_result_t;

	localparam int unsigned EXP_WHOLE[12] = '{65536, 24109, 8869, 3263, 1200, 442,
		162, 60, 22, 8, 3, 1};
	localparam int unsigned EXP_PART[16] = '{65536, 61565, 57835, 54331, 51039, 47947,
		45042, 42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};

	logic [14:0]        centre_tab [RULES*INPUTS];
	logic [12:0]        spread_tab [RULES*INPUTS];
	logic signed [1:0]  mark_tab   [RULES*INPUTS];
	logic signed [14:0] cons_tab   [RULES];
	steer_result_t      steer_expected [$];

	function automatic longint unsigned gauss_mu(input logic [15:0] x, input logic [14:0] c,
			input logic [12:0] w, input logic signed [1:0] m);
		longint unsigned d, wsq, q;
		if (m == fsi_pkg::MARK_ABOVE && x > c) return 65536;
		if (m == fsi_pkg::MARK_BELOW && x < c) return 65536;
		wsq = (w == 0) ? 1 : longint'(w) * longint'(w);
		d = (x >= c) ? x - c : c - x;
		q = (16 * d * d + wsq) / (2 * wsq);
		if (q >= 192) return 0;
		return (longint'(EXP_WHOLE[q >> 4]) * EXP_PART[q & 15] + 32768) >> 16;
	endfunction

	function automatic steer_result_t infer_steer(input logic [15:0] x [INPUTS]);
		steer_result_t res;
		longint unsigned firing, den, mag, quo;
		longint num;
		int idx;
		den = 0;
		num = 0;
		for (int r = 0; r < RULES; r++) begin
			firing = 65536;
			for (int k = 0; k < INPUTS; k++) begin
				idx = r * INPUTS + k;
				firing = (firing * gauss_mu(x[k], centre_tab[idx], spread_tab[idx],
					mark_tab[idx]) + 32768) >> 16;
			end
			den += firing;
			num += longint'(firing) * longint'(cons_tab[r]);
		end
		res.floored = (den < 1);
		if (den < 1) den = 1;
		mag = (num < 0) ? -num : num;
		quo = (mag + den / 2) / den;
		res.steer = 15'((num < 0) ? -quo : quo);
		return res;
	endfunction

	assign pending = steer_expected.size();

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] x [INPUTS];
		steer_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < RULES*INPUTS; i++) begin
				mark_tab[i] = '0;
				centre_tab[i] = '0;
				spread_tab[i] = '0;
			end
			for (int i = 0; i < RULES; i++) cons_tab[i] = '0;
			errors = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (steer_expected.size() == 0) begin
					$error("unexpected output transfer, steer %0d", steer);
					errors++;
				end else begin
					want = steer_expected.pop_front();
					if (steer !== want.steer) begin
						$error("steer expected %0d actual %0d", want.steer, steer);
						errors++;
					end
					if (den_floored !== want.floored) begin
						$error("den_floored expected %0d actual %0d", want.floored,
							den_floored);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (func)
					fsi_pkg::FUNC_SET: if (rule_index < RULES && input_index < INPUTS) begin
						centre_tab[rule_index*INPUTS + input_index] = centre;
						spread_tab[rule_index*INPUTS + input_index] = spread;
						mark_tab[rule_index*INPUTS + input_index] = edge_mark;
					end
					fsi_pkg::FUNC_CONS: if (rule_index < RULES) cons_tab[rule_index] = consequent;
					fsi_pkg::FUNC_EVAL: begin
						x[0] = dist0;
						x[1] = dist1;
						x[2] = dist2;
						x[3] = dist3;
						steer_expected.push_back(infer_steer(x));
					end
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> sim/fuzzy_steering_inference_top_tb.sv
// ----------------------------------------------------------------------------
// Fuzzy steering inference testbench
// Loads a full rule table, runs directed corner items (extreme distances,
// zero and maximum widths, every boundary mark, ignored writes and codes,
// a floored denominator), then a long random mix of table writes and
// evaluates with random gaps and output back-pressure, including one long
// hold-off that fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module fuzzy_steering_inference_top_tb;

	localparam logic [1:0] FUNC_NONE      = 2'd3;
	localparam logic [1:0] MARK_NONE      = 2'b00;
	localparam logic [1:0] MARK_ALT_NONE  = 2'b10;
	localparam int         RULES          = fsi_pkg::DEF_NUM_RULES;
	localparam int         INPUTS         = fsi_pkg::DEF_NUM_INPUTS;
	localparam int         RANDOM_ITEMS   = 485;
	localparam int         CYCLE_LIMIT    = 600000;
	localparam int         HOLD_CYCLES    = 1500;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         func = FUNC_NONE;
	logic [3:0]         rule_index = '0;
	logic [1:0]         input_index = '0;
	logic [14:0]        centre = '0;
	logic [12:0]        spread = '0;
	logic signed [1:0]  edge_mark = '0;
	logic signed [14:0] consequent = '0;
	logic [15:0]        dist0 = '0, dist1 = '0, dist2 = '0, dist3 = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [14:0] steer;
	logic               den_floored;
	int                 errors, pending;
	int                 cycles = 0;
	bit                 tx_quiet = 1'b0;
	bit                 hold_req = 1'b0;

	always #6 clk = ~clk;

	fuzzy_steering_inference_top i_dut (.*);

	fuzzy_steering_inference_checker i_checker (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stalls, a quiet stretch, and one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall = 1'b0;
			end else if (cycles > 40000 && cycles < 55000) begin
				out_stall = 1'b0;
			end else begin
				out_stall = ($urandom_range(0, 99) < 12);
			end
		end
	end

	task automatic transfer();
		while (!tx_quiet && $urandom_range(0, 99) < 12) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic set_write(input logic [3:0] r, input logic [1:0] j, input logic [14:0] c,
			input logic [12:0] w, input logic [1:0] m);
		func = fsi_pkg::FUNC_SET;
		rule_index = r;
		input_index = j;
		centre = c;
		spread = w;
		edge_mark = m;
		transfer();
	endtask

	task automatic cons_write(input logic [3:0] r, input logic [14:0] v);
		func = fsi_pkg::FUNC_CONS;
		rule_index = r;
		consequent = v;
		transfer();
	endtask

	task automatic evaluate(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
			input logic [15:0] d);
		func = fsi_pkg::FUNC_EVAL;
		dist0 = a;
		dist1 = b;
		dist2 = c;
		dist3 = d;
		transfer();
	endtask

	function automatic logic [15:0] rand_dist();
		return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24576));
	endfunction

	function automatic logic [1:0] rand_mark();
		return 2'($urandom_range(0, 3));
	endfunction

	initial begin
		int kind;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// full table load; no mark above yet so far distances floor
		for (int r = 0; r < RULES; r++) begin
			for (int j = 0; j < INPUTS; j++)
				set_write(4'(r), 2'(j), 15'($urandom_range(0, 20480)),
					13'($urandom_range(1229, 4096)),
					($urandom_range(0, 1) ? MARK_NONE : fsi_pkg::MARK_BELOW));
			cons_write(4'(r), 15'($signed($urandom_range(0, 24576)) - 12288));
		end
		evaluate(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		evaluate('0, '0, '0, '0);
		cons_write(4'd0, -15'sd12288);
		cons_write(4'd1, 15'sd12288);
		set_write(4'd0, 2'd0, 15'd0, 13'd0, MARK_NONE);
		set_write(4'd0, 2'd1, 15'h7FFF, 13'h1FFF, MARK_ALT_NONE);
		set_write(4'd1, 2'd0, 15'd20480, 13'd1229, fsi_pkg::MARK_ABOVE);
		set_write(4'd1, 2'd1, 15'd0, 13'd4096, fsi_pkg::MARK_BELOW);
		set_write(4'd15, 2'd3, 15'h7FFF, 13'h1FFF, fsi_pkg::MARK_ABOVE);
		cons_write(4'd12, 15'sd5);
		func = FUNC_NONE;
		transfer();
		evaluate('0, 16'h7FFF, '0, '0);
		evaluate(16'd20480, '0, 16'd20480, 16'd20480);
		evaluate(16'hFFFF, '0, 16'h1000, 16'h2000);
		evaluate(16'd1, 16'd32766, 16'd10240, 16'd4096);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			tx_quiet = (n >= 300 && n < 380);
			if (n == 150) hold_req = 1'b1;
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				evaluate(rand_dist(), rand_dist(), rand_dist(), rand_dist());
			end else if (kind < 87) begin
				if ($urandom_range(0, 7) == 0)
					set_write(4'($urandom_range(0, 15)), 2'($urandom), 15'($urandom),
						13'($urandom), rand_mark());
				else
					set_write(4'($urandom_range(0, RULES-1)), 2'($urandom_range(0, INPUTS-1)),
						15'($urandom_range(0, 20480)), 13'($urandom_range(1229, 4096)),
						rand_mark());
			end else if (kind < 97) begin
				cons_write(4'($urandom_range(0, 15)),
					15'($signed($urandom_range(0, 24576)) - 12288));
			end else begin
				func = FUNC_NONE;
				rule_index = 4'($urandom);
				transfer();
			end
		end

		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl
rtl/fsi_pkg.sv
rtl/fsi_lane.sv
rtl/fsi_divider.sv
rtl/fuzzy_steering_inference_top.sv
sim/fuzzy_steering_inference_checker.sv
sim/fuzzy_steering_inference_top_tb.sv
